[design/gmd_pkg.sv]
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared types, codes and defaults of the grid maze depth-first path finder.
// ----------------------------------------------------------------------------
package gmd_pkg;

    localparam int GRID_SIZE_DEF = 10;

    // action codes of an input beat
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_RUN  = 2'd1;
    localparam logic [1:0] ACT_PATH = 2'd2;
    localparam logic [1:0] ACT_CELL = 2'd3;

    // cell codes
    localparam logic [2:0] CELL_WALL    = 3'd0;
    localparam logic [2:0] CELL_OPEN    = 3'd1;
    localparam logic [2:0] CELL_START   = 3'd2;
    localparam logic [2:0] CELL_END     = 3'd3;
    localparam logic [2:0] CELL_VISITED = 3'd4;
    localparam logic [2:0] CELL_PATH    = 3'd5;

    // neighbor order: up, right, down, left, then exhausted
    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;

    // configuration register indexes
    localparam logic REG_START_ROW = 1'b0;
    localparam logic REG_START_COL = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] row;
        logic [3:0] col;
        logic [2:0] cell_code;
        logic [7:0] path_index;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] path_length;
        logic [3:0] out_row;
        logic [3:0] out_col;
        logic [2:0] out_cell;
        logic       index_error;
    } t_out_item;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_START_CK,
        CMD_STEP,
        CMD_POP_LOAD,
        CMD_NB_CK,
        CMD_MARK_RD,
        CMD_MARK_WR,
        CMD_READ_DONE,
        CMD_SEND
    } t_cmd;

    typedef struct packed {
        logic depth_zero;
        logic depth_one;
        logic dir_done;
        logic nb_inside;
        logic start_go;
        logic nb_end;
        logic k_last;
    } t_dp_status;

endpackage

[design/gmd_in_if.sv]
// ----------------------------------------------------------------------------
// gmd_in_if
// Input channel: valid/ready handshake carrying one action beat.
// ----------------------------------------------------------------------------
interface gmd_in_if;
    logic               valid;
    logic               ready;
    gmd_pkg::t_in_item  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[design/gmd_out_if.sv]
// ----------------------------------------------------------------------------
// gmd_out_if
// Output channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface gmd_out_if;
    logic               valid;
    logic               ready;
    gmd_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[design/grid_maze_dfs_path_finder.sv]
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_finder
// Depth-first path search on a square grid held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one beat per action: load cell, run search,
// read path entry or read cell. Each accepted beat yields exactly one result
// beat carrying the found flag and path length of the last search, plus the
// read data and an index error flag. Start row and column are set through a
// plain write port; the user must write them only while the block is idle,
// as the block itself does not enforce it. A load beat goes straight to the
// result state; path and cell reads pass through a read-wait state first.
// A search reads one neighbor probe at a time through the single grid read
// port, pops the stack on a backtrack, then marks the path cells in a sweep.
// One beat is in flight at a time: input ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it there
// and the block still takes the next input beat.
// Reset clears the found flag, path length and stack depth, and sets the
// start to row 1, column 0. Grid and stack memories are not cleared: load
// every cell before searching.
// ----------------------------------------------------------------------------
module grid_maze_dfs_path_finder #(
    parameter int GRID_SIZE = gmd_pkg::GRID_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gmd_in_if.sink       i_in,
    gmd_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [3:0]   i_cfg_data
);
    import gmd_pkg::*;

    t_cmd       cmd;
    t_dp_status status;
    logic       in_ready, out_valid;
    t_out_item  out_item;

    // sequencer: owns handshakes and the search walk
    gmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.item.action),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath: memories, stack top, counters and result register
    gmd_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_item     (out_item)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.item  = out_item;
endmodule

[design/gmd_ram.sv]
// ----------------------------------------------------------------------------
// gmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/gmd_ctrl.sv]
// ----------------------------------------------------------------------------
// gmd_ctrl
// Sequencer: steps the datapath through load, read and search commands.
// ----------------------------------------------------------------------------
module gmd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  gmd_pkg::t_dp_status i_status,
    output gmd_pkg::t_cmd       o_cmd
);
    import gmd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_CK,
        S_STEP,
        S_POP_WAIT,
        S_NB_CK,
        S_MARK_RD,
        S_MARK_WR,
        S_RD_WAIT,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd = CMD_NONE;
        case (r_state)
            S_IDLE:     if (i_in_valid) cmd = CMD_ACCEPT;
            S_START_CK: cmd = CMD_START_CK;
            S_STEP:     cmd = CMD_STEP;
            S_POP_WAIT: cmd = CMD_POP_LOAD;
            S_NB_CK:    cmd = CMD_NB_CK;
            S_MARK_RD:  cmd = CMD_MARK_RD;
            S_MARK_WR:  cmd = CMD_MARK_WR;
            S_RD_WAIT:  cmd = CMD_READ_DONE;
            S_RESP:     if (!r_out_valid || i_out_ready) cmd = CMD_SEND;
            default:    cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cmd == CMD_SEND) begin
                r_out_valid <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_action == ACT_LOAD) begin
                            r_state <= S_RESP;
                        end else if (i_action == ACT_RUN) begin
                            r_state <= S_START_CK;
                        end else begin
                            r_state <= S_RD_WAIT;
                        end
                    end
                end
                S_START_CK: r_state <= i_status.start_go ? S_STEP : S_RESP;
                S_STEP: begin
                    if (i_status.depth_zero) begin
                        r_state <= S_RESP;
                    end else if (i_status.dir_done) begin
                        r_state <= i_status.depth_one ? S_RESP : S_POP_WAIT;
                    end else if (i_status.nb_inside) begin
                        r_state <= S_NB_CK;
                    end
                end
                S_POP_WAIT: r_state <= S_STEP;
                S_NB_CK:    r_state <= i_status.nb_end ? S_MARK_RD : S_STEP;
                S_MARK_RD:  r_state <= S_MARK_WR;
                S_MARK_WR:  r_state <= i_status.k_last ? S_RESP : S_MARK_RD;
                S_RD_WAIT:  r_state <= S_RESP;
                S_RESP:     if (cmd == CMD_SEND) r_state <= S_IDLE;
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

[design/gmd_dp.sv]
// ----------------------------------------------------------------------------
// gmd_dp
// Datapath: grid and stack memories, top-of-stack, counters, result register.
// ----------------------------------------------------------------------------
module gmd_dp #(
    parameter int GRID_SIZE = gmd_pkg::GRID_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [3:0]          i_cfg_data,
    input  gmd_pkg::t_in_item   i_item,
    input  gmd_pkg::t_cmd       i_cmd,
    output gmd_pkg::t_dp_status o_status,
    output gmd_pkg::t_out_item  o_item
);
    import gmd_pkg::*;

    localparam int RW    = $clog2(GRID_SIZE);
    localparam int CAW   = 2 * RW;
    localparam int GDEP  = 2 ** CAW;
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int SAW   = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int SW    = CAW + 3;

    logic [3:0]     r_start_row, r_start_col;
    logic [1:0]     r_action;
    logic           r_found;
    logic [DW-1:0]  r_count, r_depth, r_k;
    logic [CAW-1:0] r_top_cell, r_nb_addr;
    logic [2:0]     r_top_dir;
    logic [3:0]     r_aux_row, r_aux_col;
    logic [2:0]     r_aux_cell;
    logic           r_aux_err;
    t_out_item      r_out;

    logic           g_we, g_re;
    logic [CAW-1:0] g_waddr, g_raddr;
    logic [2:0]     g_wdata, g_rdata;
    logic           s_we, s_re;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;

    logic           item_inside, start_inside, pidx_ok, nb_inside;
    logic           walk, is_end;
    logic [CAW-1:0] item_addr, start_addr, nb_addr;
    logic [RW-1:0]  top_row, top_col, nb_row, nb_col;
    logic [DW-1:0]  depth_m1, depth_m2;
    logic [DW+7:0]  count_ext;

    assign item_inside  = ({1'b0, i_item.row} < 5'(GRID_SIZE))
                       && ({1'b0, i_item.col} < 5'(GRID_SIZE));
    assign start_inside = ({1'b0, r_start_row} < 5'(GRID_SIZE))
                       && ({1'b0, r_start_col} < 5'(GRID_SIZE));
    assign item_addr    = {i_item.row[RW-1:0], i_item.col[RW-1:0]};
    assign start_addr   = {r_start_row[RW-1:0], r_start_col[RW-1:0]};
    assign pidx_ok      = (9'(i_item.path_index) < 9'(r_count));

    assign top_row  = r_top_cell[CAW-1:RW];
    assign top_col  = r_top_cell[RW-1:0];
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    // neighbor in the current direction, with its bounds check
    always_comb begin
        nb_row    = top_row;
        nb_col    = top_col;
        nb_inside = 1'b0;
        case (r_top_dir)
            DIR_UP: begin
                nb_row    = top_row - RW'(1);
                nb_inside = (top_row != '0);
            end
            DIR_RIGHT: begin
                nb_col    = top_col + RW'(1);
                nb_inside = (top_col != RW'(GRID_SIZE - 1));
            end
            DIR_DOWN: begin
                nb_row    = top_row + RW'(1);
                nb_inside = (top_row != RW'(GRID_SIZE - 1));
            end
            DIR_LEFT: begin
                nb_col    = top_col - RW'(1);
                nb_inside = (top_col != '0);
            end
            default: nb_inside = 1'b0;
        endcase
    end
    assign nb_addr = {nb_row, nb_col};

    assign walk   = (g_rdata == CELL_OPEN) || (g_rdata == CELL_START) || (g_rdata == CELL_END);
    assign is_end = (g_rdata == CELL_END);

    assign o_status.depth_zero = (r_depth == '0);
    assign o_status.depth_one  = (r_depth == DW'(1));
    assign o_status.dir_done   = (r_top_dir == DIR_DONE);
    assign o_status.nb_inside  = nb_inside;
    assign o_status.start_go   = start_inside && walk && !is_end;
    assign o_status.nb_end     = walk && is_end;
    assign o_status.k_last     = ((r_k + DW'(1)) == r_count);

    // memory port steering
    always_comb begin
        g_we    = 1'b0;
        g_waddr = item_addr;
        g_wdata = CELL_WALL;
        g_re    = 1'b0;
        g_raddr = item_addr;
        s_we    = 1'b0;
        s_waddr = depth_m1[SAW-1:0];
        s_wdata = {r_top_dir, r_top_cell};
        s_re    = 1'b0;
        s_raddr = i_item.path_index[SAW-1:0];
        case (i_cmd)
            CMD_ACCEPT: begin
                case (i_item.action)
                    ACT_LOAD: begin
                        g_we    = item_inside;
                        g_wdata = (i_item.cell_code <= CELL_PATH) ? i_item.cell_code
                                                                  : CELL_WALL;
                    end
                    ACT_RUN: begin
                        g_re    = start_inside;
                        g_raddr = start_addr;
                    end
                    ACT_PATH: s_re = pidx_ok;
                    default:  g_re = item_inside;
                endcase
            end
            CMD_START_CK: begin
                g_we    = o_status.start_go;
                g_waddr = start_addr;
                g_wdata = CELL_VISITED;
            end
            CMD_STEP: begin
                if (!o_status.depth_zero) begin
                    if (o_status.dir_done) begin
                        s_re    = !o_status.depth_one;
                        s_raddr = depth_m2[SAW-1:0];
                    end else begin
                        g_re    = nb_inside;
                        g_raddr = nb_addr;
                    end
                end
            end
            CMD_NB_CK: begin
                if (walk) begin
                    if (is_end) begin
                        s_we = 1'b1;
                    end else begin
                        g_we    = 1'b1;
                        g_waddr = r_nb_addr;
                        g_wdata = CELL_VISITED;
                        s_we    = (r_depth < DW'(CELLS));
                    end
                end
            end
            CMD_MARK_RD: begin
                s_re    = 1'b1;
                s_raddr = r_k[SAW-1:0];
            end
            CMD_MARK_WR: begin
                g_we    = 1'b1;
                g_waddr = s_rdata[CAW-1:0];
                g_wdata = CELL_PATH;
            end
            default: ;
        endcase
    end

    assign count_ext = {8'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= 4'd1;
            r_start_col <= 4'd0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_depth     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_ROW: r_start_row <= i_cfg_data;
                    default:       r_start_col <= i_cfg_data;
                endcase
            end
            case (i_cmd)
                CMD_ACCEPT: begin
                    if (i_item.action == ACT_RUN) begin
                        r_found <= 1'b0;
                        r_count <= '0;
                        r_depth <= '0;
                    end
                end
                CMD_START_CK: begin
                    if (start_inside && walk) begin
                        if (is_end) begin
                            r_found <= 1'b1;
                        end else begin
                            r_depth <= DW'(1);
                        end
                    end
                end
                CMD_STEP: begin
                    if (!o_status.depth_zero && o_status.dir_done) begin
                        r_depth <= depth_m1;
                    end
                end
                CMD_NB_CK: begin
                    if (walk) begin
                        if (is_end) begin
                            r_found <= 1'b1;
                            r_count <= r_depth;
                        end else if (r_depth < DW'(CELLS)) begin
                            r_depth <= r_depth + DW'(1);
                        end
                    end
                end
                CMD_MARK_WR: begin
                    if (o_status.k_last) begin
                        r_depth <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers: top of stack, item scratch, result beat
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_ACCEPT: begin
                r_action   <= i_item.action;
                r_aux_row  <= '0;
                r_aux_col  <= '0;
                r_aux_cell <= CELL_WALL;
                case (i_item.action)
                    ACT_RUN:  r_aux_err <= 1'b0;
                    ACT_PATH: r_aux_err <= !pidx_ok;
                    default:  r_aux_err <= !item_inside;
                endcase
            end
            CMD_START_CK: begin
                r_top_cell <= start_addr;
                r_top_dir  <= DIR_UP;
            end
            CMD_STEP: begin
                if (!o_status.depth_zero && !o_status.dir_done) begin
                    r_top_dir <= r_top_dir + 3'd1;
                    r_nb_addr <= nb_addr;
                end
            end
            CMD_POP_LOAD: begin
                r_top_cell <= s_rdata[CAW-1:0];
                r_top_dir  <= s_rdata[SW-1:CAW];
            end
            CMD_NB_CK: begin
                if (walk && is_end) begin
                    r_k <= '0;
                end else if (walk && (r_depth < DW'(CELLS))) begin
                    r_top_cell <= r_nb_addr;
                    r_top_dir  <= DIR_UP;
                end
            end
            CMD_MARK_WR: r_k <= r_k + DW'(1);
            CMD_READ_DONE: begin
                if (!r_aux_err) begin
                    if (r_action == ACT_PATH) begin
                        r_aux_row <= 4'(s_rdata[CAW-1:RW]);
                        r_aux_col <= 4'(s_rdata[RW-1:0]);
                    end else begin
                        r_aux_cell <= g_rdata;
                    end
                end
            end
            CMD_SEND: begin
                r_out.found       <= r_found;
                r_out.path_length <= count_ext[7:0];
                r_out.out_row     <= r_aux_row;
                r_out.out_col     <= r_aux_col;
                r_out.out_cell    <= r_aux_cell;
                r_out.index_error <= r_aux_err;
            end
            default: ;
        endcase
    end

    assign o_item = r_out;

    gmd_ram #(.WIDTH(3), .DEPTH(GDEP)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    gmd_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );
endmodule
